FILE: src/hsv_pkg.sv
package hsv_pkg;

  localparam int unsigned PixW  = 8;
  localparam int unsigned ProdW = 2 * PixW;
  localparam int unsigned WideW = 3 * PixW;

  localparam logic [PixW-1:0]  FullS   = 8'd255;
  localparam logic [PixW:0]    FracOne = 9'd256;
  localparam logic [ProdW-1:0] ScaleQt = 16'd65280;

  localparam logic [2:0] SEC_0 = 3'd0;
  localparam logic [2:0] SEC_1 = 3'd1;
  localparam logic [2:0] SEC_2 = 3'd2;
  localparam logic [2:0] SEC_3 = 3'd3;
  localparam logic [2:0] SEC_4 = 3'd4;
  localparam logic [2:0] SEC_5 = 3'd5;

  typedef logic [PixW-1:0] pix_t;
  typedef logic [ProdW-1:0] prod_t;
  typedef logic [2:0] sector_t;

  typedef struct packed {
    sector_t sector;
    pix_t    frac;
    pix_t    sat;
    pix_t    val;
  } st1_t;

  typedef struct packed {
    sector_t sector;
    pix_t    val;
    prod_t   nq;
    prod_t   nt;
    prod_t   yp;
  } st2_t;

  typedef struct packed {
    sector_t sector;
    pix_t    val;
    prod_t   yq;
    prod_t   yt;
    prod_t   yp;
  } st3_t;

  typedef struct packed {
    sector_t sector;
    pix_t    val;
    pix_t    p;
    pix_t    q;
    pix_t    t;
  } st4_t;

endpackage

FILE: src/hsv_in_if.sv
interface hsv_in_if;
  import hsv_pkg::*;
  logic valid;
  logic ready;
  pix_t hue;
  pix_t saturation;
  pix_t brightness;

  modport source (output valid, output hue, output saturation, output brightness, input ready);
  modport sink   (input valid, input hue, input saturation, input brightness, output ready);
endinterface

FILE: src/hsv_out_if.sv
interface hsv_out_if;
  import hsv_pkg::*;
  logic valid;
  logic ready;
  pix_t red;
  pix_t green;
  pix_t blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

FILE: src/hsv_to_rgb_converter_unit.sv
// HSV to RGB pixel converter, five register stages.
// Throughput: one word per cycle; each stage holds on a stall and refills
// as soon as it empties, so stalls lose and repeat nothing.
// Reset (synchronous, rst high) empties every stage; no other state.
module hsv_to_rgb_converter_unit
  import hsv_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  hsv_in_if.sink    hsv,
  hsv_out_if.source rgb
);

  logic [4:0] vld;
  logic [4:0] en;

  st1_t s1;
  st2_t s2;
  st3_t s3;
  st4_t s4;
  pix_t red_r, green_r, blue_r;

  logic [10:0] h6;
  pix_t        dq, dt, dp;
  pix_t        r_next, g_next, b_next;
  logic [WideW-1:0] xq, xt;

  always_comb begin
    en[4] = !vld[4] || rgb.ready;
    en[3] = !vld[3] || en[4];
    en[2] = !vld[2] || en[3];
    en[1] = !vld[1] || en[2];
    en[0] = !vld[0] || en[1];
  end

  assign hsv.ready = en[0];
  assign rgb.valid = vld[4];
  assign rgb.red   = red_r;
  assign rgb.green = green_r;
  assign rgb.blue  = blue_r;

  // 6*hue = 2*hue + 4*hue
  assign h6 = {2'b00, hsv.hue, 1'b0} + {1'b0, hsv.hue, 2'b00};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= hsv.valid;
      if (en[1]) vld[1] <= vld[0];
      if (en[2]) vld[2] <= vld[1];
      if (en[3]) vld[3] <= vld[2];
      if (en[4]) vld[4] <= vld[3];
    end
  end

  // stage 1: sector and fraction
  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1.sector <= h6[10:8];
      s1.frac   <= h6[7:0];
      s1.sat    <= hsv.saturation;
      s1.val    <= hsv.brightness;
    end
  end

  // stage 2: weighted saturation, p numerator
  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2.sector <= s1.sector;
      s2.val    <= s1.val;
      s2.nq     <= ScaleQt - prod_t'(s1.frac * s1.sat);
      s2.nt     <= ScaleQt - prod_t'((FracOne - {1'b0, s1.frac}) * s1.sat);
      s2.yp     <= prod_t'(s1.val * (FullS - s1.sat));
    end
  end

  // stage 3: q and t products, pre-shifted by 256
  assign xq = WideW'(s2.val * s2.nq);
  assign xt = WideW'(s2.val * s2.nt);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3.sector <= s2.sector;
      s3.val    <= s2.val;
      s3.yq     <= xq[WideW-1:PixW];
      s3.yt     <= xt[WideW-1:PixW];
      s3.yp     <= s2.yp;
    end
  end

  // stage 4: divide by 255
  hsv_div255 u_div_p (.num(s3.yp), .quo(dp));
  hsv_div255 u_div_q (.num(s3.yq), .quo(dq));
  hsv_div255 u_div_t (.num(s3.yt), .quo(dt));

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4.sector <= s3.sector;
      s4.val    <= s3.val;
      s4.p      <= dp;
      s4.q      <= dq;
      s4.t      <= dt;
    end
  end

  // stage 5: route terms by sector
  always_comb begin
    unique case (s4.sector)
      SEC_0: begin r_next = s4.val; g_next = s4.t;   b_next = s4.p;   end
      SEC_1: begin r_next = s4.q;   g_next = s4.val; b_next = s4.p;   end
      SEC_2: begin r_next = s4.p;   g_next = s4.val; b_next = s4.t;   end
      SEC_3: begin r_next = s4.p;   g_next = s4.q;   b_next = s4.val; end
      SEC_4: begin r_next = s4.t;   g_next = s4.p;   b_next = s4.val; end
      default: begin r_next = s4.val; g_next = s4.p; b_next = s4.q;   end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      red_r   <= r_next;
      green_r <= g_next;
      blue_r  <= b_next;
    end
  end

endmodule

FILE: src/hsv_div255.sv
module hsv_div255
  import hsv_pkg::*;
(
  input  prod_t num,
  output pix_t  quo
);

  // num below 65280: floor(num/255) is num>>8 or one more
  pix_t          q0;
  logic [PixW:0] rem;

  always_comb begin
    q0  = num[ProdW-1:PixW];
    rem = {1'b0, num[PixW-1:0]} + {1'b0, q0};
    quo = (rem >= {1'b0, FullS}) ? q0 + pix_t'(1) : q0;
  end

endmodule

FILE: tb/hsv_to_rgb_converter_unit_tb.sv
module hsv_to_rgb_converter_unit_tb;
  import hsv_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 20;

  typedef struct packed {
    pix_t red;
    pix_t green;
    pix_t blue;
  } rgb_t;

  logic clk;
  logic rst;

  hsv_in_if hsv ();
  hsv_out_if rgb ();

  hsv_to_rgb_converter_unit i_dut (
    .clk (clk),
    .rst (rst),
    .hsv (hsv),
    .rgb (rgb)
  );

  rgb_t pending_rgb[$];
  int unsigned mismatches;
  int unsigned cycle_count;
  bit src_gaps;
  bit sink_stalls;
  int unsigned hold_off_left;
  int unsigned stall_left;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic rgb_t rgb_from_hsv(pix_t h, pix_t s, pix_t v);
    logic [10:0] h6;
    sector_t sec;
    int unsigned fw;
    int unsigned sw;
    int unsigned vw;
    int unsigned p;
    int unsigned q;
    int unsigned t;
    rgb_t c;
    h6 = 11'(h) * 11'd6;
    sec = h6[10:8];
    fw = 32'(h6[7:0]);
    sw = 32'(s);
    vw = 32'(v);
    p = (vw * (255 - sw)) / 255;
    q = (vw * (65280 - fw * sw)) / 65280;
    t = (vw * (65280 - (256 - fw) * sw)) / 65280;
    case (sec)
      SEC_0: c = '{pix_t'(vw), pix_t'(t), pix_t'(p)};
      SEC_1: c = '{pix_t'(q), pix_t'(vw), pix_t'(p)};
      SEC_2: c = '{pix_t'(p), pix_t'(vw), pix_t'(t)};
      SEC_3: c = '{pix_t'(p), pix_t'(q), pix_t'(vw)};
      SEC_4: c = '{pix_t'(t), pix_t'(p), pix_t'(vw)};
      default: c = '{pix_t'(vw), pix_t'(p), pix_t'(q)};
    endcase
    return c;
  endfunction

  // called and returns at a falling edge; valid is left high for the next word
  task automatic send_pixel(pix_t h, pix_t s, pix_t v);
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      hsv.valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    hsv.valid = 1'b1;
    hsv.hue = h;
    hsv.saturation = s;
    hsv.brightness = v;
    @(posedge clk);
    while (!hsv.ready) @(posedge clk);
    pending_rgb.push_back(rgb_from_hsv(h, s, v));
    @(negedge clk);
  endtask

  task automatic send_random_pixel();
    pix_t h;
    pix_t s;
    pix_t v;
    h = pix_t'($urandom);
    s = pix_t'($urandom);
    v = pix_t'($urandom);
    case ($urandom_range(0, 9))
      0: s = 8'd0;
      1: s = 8'd255;
      2: v = 8'd0;
      3: v = 8'd255;
      default: ;
    endcase
    send_pixel(h, s, v);
  endtask

  task automatic wait_drained();
    hsv.valid = 1'b0;
    while (pending_rgb.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed();
    pix_t hues[12];
    hues = '{8'd0, 8'd1, 8'd42, 8'd43, 8'd85, 8'd86, 8'd128, 8'd170, 8'd171,
             8'd213, 8'd214, 8'd255};
    src_gaps = 1'b0;
    sink_stalls = 1'b0;
    foreach (hues[i]) send_pixel(hues[i], 8'd255, 8'd255);
    send_pixel(8'd100, 8'd0, 8'd200);   // grey
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd200, 8'd255, 8'd0);   // black
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd30, 8'd128, 8'd255);
    send_pixel(8'd130, 8'd1, 8'd1);
    send_pixel(8'd170, 8'd254, 8'd254);
    send_pixel(8'h55, 8'hAA, 8'h55);
    send_pixel(8'hAA, 8'h55, 8'hAA);
    wait_drained();
  endtask

  task automatic test_random_idling();
    repeat (10) begin
      src_gaps = 1'($urandom_range(0, 1));
      sink_stalls = 1'($urandom_range(0, 1));
      repeat (25) send_random_pixel();
    end
  endtask

  task automatic test_backpressure();
    src_gaps = 1'b0;
    sink_stalls = 1'b0;
    hold_off_left = 40;
    repeat (60) send_random_pixel();
  endtask

  task automatic test_pause_drain();
    src_gaps = 1'b1;
    sink_stalls = 1'b1;
    repeat (10) send_random_pixel();
    wait_drained();
    repeat (10) send_random_pixel();
  endtask

  task automatic test_streaming();
    src_gaps = 1'b0;
    sink_stalls = 1'b0;
    repeat (80) send_random_pixel();
  endtask

  // receiver: ready held low during a hold-off, otherwise bursts of stall when sink_stalls is set
  initial begin
    rgb.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        rgb.ready = 1'b0;
        hold_off_left = hold_off_left - 1;
      end else if (stall_left > 0) begin
        rgb.ready = 1'b0;
        stall_left = stall_left - 1;
      end else begin
        rgb.ready = 1'b1;
        if (sink_stalls && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 10);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rgb.valid && rgb.ready) begin
      if (pending_rgb.size() == 0) begin
        $display("%0t: unexpected word r=%0d g=%0d b=%0d", $time, rgb.red, rgb.green,
                 rgb.blue);
        mismatches++;
      end else begin
        rgb_t exp_rgb;
        exp_rgb = pending_rgb.pop_front();
        if (rgb.red !== exp_rgb.red) begin
          $display("%0t: red expected %0d actual %0d", $time, exp_rgb.red, rgb.red);
          mismatches++;
        end
        if (rgb.green !== exp_rgb.green) begin
          $display("%0t: green expected %0d actual %0d", $time, exp_rgb.green, rgb.green);
          mismatches++;
        end
        if (rgb.blue !== exp_rgb.blue) begin
          $display("%0t: blue expected %0d actual %0d", $time, exp_rgb.blue, rgb.blue);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    mismatches = 0;
    cycle_count = 0;
    src_gaps = 1'b0;
    sink_stalls = 1'b0;
    hold_off_left = 0;
    stall_left = 0;
    rst = 1'b1;
    hsv.valid = 1'b0;
    hsv.hue = '0;
    hsv.saturation = '0;
    hsv.brightness = '0;
    repeat (5) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    test_directed();
    test_random_idling();
    test_backpressure();
    test_pause_drain();
    test_streaming();

    wait_drained();
    repeat (DrainCycles) @(negedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
